[design/loki_pkg.sv]
package loki_pkg;

  localparam logic [24:0] S1_GEN = 25'h0002911;
  localparam logic [20:0] S2_GEN = 21'h000AA7;
  localparam logic [63:0] DELTA_WORD = 64'h9E3779B97F4A7C15;
  localparam logic [12:0] S1_MASK = 13'h1FFF;
  localparam logic [10:0] S2_MASK = 11'h7FF;

  localparam logic [2:0] CFG_KEY_A = 3'd0;
  localparam logic [2:0] CFG_KEY_B = 3'd1;
  localparam logic [2:0] CFG_KEY_C = 3'd2;
  localparam logic [2:0] CFG_KEY_D = 3'd3;
  localparam logic [2:0] CFG_KEY_SIZE = 3'd4;
  localparam logic [2:0] CFG_MODE = 3'd5;
  localparam logic [2:0] CFG_IV_LEFT = 3'd6;
  localparam logic [2:0] CFG_IV_RIGHT = 3'd7;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;
  localparam logic [1:0] KEY_256 = 2'd2;

  localparam logic [2:0] MODE_ECB_ENC = 3'd0;
  localparam logic [2:0] MODE_ECB_DEC = 3'd1;
  localparam logic [2:0] MODE_CBC_ENC = 3'd2;
  localparam logic [2:0] MODE_CBC_DEC = 3'd3;
  localparam logic [2:0] MODE_CFB_ENC = 3'd4;
  localparam logic [2:0] MODE_CFB_DEC = 3'd5;
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_E,
    ST_PRE_F,
    ST_KS_ADD,
    ST_KS_E,
    ST_KS_F,
    ST_BK_RD,
    ST_BK_ADD,
    ST_BK_E,
    ST_BK_F,
    ST_FIN
  } state_t;

  function automatic logic [12:0] gf13_mul(logic [12:0] a, logic [12:0] b);
    logic [24:0] p;
    p = '0;
    for (int i = 0; i < 13; i++) begin
      if (b[i]) p = p ^ ({12'b0, a} << i);
    end
    for (int i = 24; i >= 13; i--) begin
      if (p[i]) p = p ^ (S1_GEN << (i - 13));
    end
    return p[12:0];
  endfunction

  function automatic logic [10:0] gf11_mul(logic [10:0] a, logic [10:0] b);
    logic [20:0] p;
    p = '0;
    for (int i = 0; i < 11; i++) begin
      if (b[i]) p = p ^ ({10'b0, a} << i);
    end
    for (int i = 20; i >= 11; i--) begin
      if (p[i]) p = p ^ (S2_GEN << (i - 11));
    end
    return p[10:0];
  endfunction

  function automatic logic [7:0] sbox1(logic [12:0] x);
    logic [12:0] a;
    logic [12:0] c;
    a = x ^ S1_MASK;
    c = gf13_mul(a, gf13_mul(a, a));
    return c[7:0];
  endfunction

  function automatic logic [7:0] sbox2(logic [10:0] x);
    logic [10:0] a;
    logic [10:0] c;
    a = x ^ S2_MASK;
    c = gf11_mul(a, gf11_mul(a, a));
    return c[7:0];
  endfunction

  function automatic logic [63:0] perm(logic [7:0] x);
    logic [63:0] v;
    v = '0;
    for (int j = 0; j < 4; j++) begin
      v[7 + 8 * j] = x[j];
      v[39 + 8 * j] = x[j + 4];
    end
    return v;
  endfunction

endpackage

[design/loki_f_unit.sv]
module loki_f_unit
  import loki_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] f
);

  logic [31:0] al, ar, bl, br, dl, dr;
  logic [63:0] e;
  logic [63:0] e_r;
  logic [31:0] bl_r;
  logic [31:0] el, er;

  always_comb begin
    al = a[63:32];
    ar = a[31:0];
    bl = b[63:32];
    br = b[31:0];
    dl = (al & ~br) | (ar & br);
    dr = (ar & ~br) | (al & br);
    e = (perm(sbox1({dr[4:0], dl[31:24]})) >> 7)
      | (perm(sbox2(dl[26:16])) >> 6)
      | (perm(sbox1(dl[20:8])) >> 5)
      | (perm(sbox2(dl[10:0])) >> 4)
      | (perm(sbox2({dl[2:0], dr[31:24]})) >> 3)
      | (perm(sbox1(dr[28:16])) >> 2)
      | (perm(sbox2(dr[18:8])) >> 1)
      | perm(sbox1(dr[12:0]));
  end

  always_ff @(posedge clk) begin
    e_r <= e;
    bl_r <= bl;
  end

  always_comb begin
    el = e_r[63:32];
    er = e_r[31:0];
    f = {sbox2({bl_r[31:29], el[31:24]}), sbox2({bl_r[28:26], el[23:16]}),
         sbox1({bl_r[25:21], el[15:8]}), sbox1({bl_r[20:16], el[7:0]}),
         sbox2({bl_r[15:13], er[31:24]}), sbox2({bl_r[12:10], er[23:16]}),
         sbox1({bl_r[9:5], er[15:8]}), sbox1({bl_r[4:0], er[7:0]})};
  end

endmodule

[design/loki97_cipher_engine_top.sv]
// Channel   Ports                                              Handshake
// input     in_restart, in_block_left, in_block_right          in_valid / in_stall
// result    out_left, out_right                                out_valid / out_stall
// config    cfg_index, cfg_data                                cfg_valid / cfg_ready
// A block runs one subkey row read, then 16 rounds (add, first S-box layer, second S-box layer)
// on the shared round unit, then the finish state; reserved modes skip the rounds.
// After reset or a key or key-size write, the first block first runs the key schedule: 48
// subkeys, after a key expansion for 128- and 192-bit keys, written as 16 rows of three.
// A new item is taken only when the engine is idle; a stalled result holds in the output
// register while the next item is taken, and the finish cycle waits for it to go.
// Reset is synchronous; the subkey memory is not cleared.
module loki97_cipher_engine_top
  import loki_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  input  logic [63:0] in_block_left,
  input  logic [63:0] in_block_right,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_left,
  output logic [63:0] out_right,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [63:0] key_a_r, key_b_r, key_c_r, key_d_r;
  logic [1:0]  key_size_r;
  logic [2:0]  mode_r;
  logic [63:0] iv_l_r, iv_rt_r;
  logic        sched_rdy_r;
  logic [63:0] chain_l_r, chain_rt_r;
  logic [63:0] k1_r, k2_r, k3_r, k4_r, delta_r, add_r;
  logic        pre_sel_r;
  logic [1:0]  ks_sub_r;
  logic [3:0]  ks_row_r;
  logic [63:0] sb0_r, sb1_r;
  logic [3:0]  rnd_r;
  logic [63:0] blk_l_r, blk_rt_r, t_r, src_l_r, src_rt_r;
  logic        msg_r;
  logic        out_valid_r;
  logic [63:0] out_l_r, out_rt_r;

  logic [191:0] sk_mem [16];
  logic [191:0] rdata_r;

  logic         in_acc, cfg_acc, dec, fin_go, ks_last;
  logic [63:0]  f_a, f_b, f_out, sk, e0, e1, e2, ch_l, ch_rt;
  logic         mem_we, rd_en;
  logic [3:0]   rd_addr, rnd_inc;
  logic         kbit, cbit, fb;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_left = out_l_r;
  assign out_right = out_rt_r;

  assign dec = (mode_r == MODE_ECB_DEC) || (mode_r == MODE_CBC_DEC);
  assign fin_go = !out_valid_r || !out_stall;
  assign ks_last = (ks_row_r == 4'd15) && (ks_sub_r == 2'd2);
  assign e0 = rdata_r[191:128];
  assign e1 = rdata_r[127:64];
  assign e2 = rdata_r[63:0];
  assign sk = k4_r ^ f_out;
  assign ch_l = in_restart ? iv_l_r : chain_l_r;
  assign ch_rt = in_restart ? iv_rt_r : chain_rt_r;
  assign rnd_inc = rnd_r + 4'd1;
  assign kbit = blk_rt_r[63];
  assign cbit = msg_r ^ kbit;
  assign fb = (mode_r == MODE_CFB_ENC) ? cbit : msg_r;

  loki_f_unit u_f (
    .clk (clk),
    .a   (f_a),
    .b   (f_b),
    .f   (f_out)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (sched_rdy_r) state_nxt = ST_BK_RD;
          else if (key_size_r == KEY_128 || key_size_r == KEY_192) state_nxt = ST_PRE_E;
          else state_nxt = ST_KS_ADD;
        end
      end
      ST_PRE_E: state_nxt = ST_PRE_F;
      ST_PRE_F: state_nxt = pre_sel_r ? ST_KS_ADD : ST_PRE_E;
      ST_KS_ADD: state_nxt = ST_KS_E;
      ST_KS_E: state_nxt = ST_KS_F;
      ST_KS_F: state_nxt = ks_last ? ST_BK_RD : ST_KS_ADD;
      ST_BK_RD: state_nxt = (mode_r inside {MODE_RSVD_6, MODE_RSVD_7}) ? ST_FIN : ST_BK_ADD;
      ST_BK_ADD: state_nxt = ST_BK_E;
      ST_BK_E: state_nxt = ST_BK_F;
      ST_BK_F: state_nxt = (rnd_r == 4'd15) ? ST_FIN : ST_BK_ADD;
      ST_FIN: state_nxt = fin_go ? ST_IDLE : ST_FIN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    f_a = t_r;
    f_b = e1;
    mem_we = 1'b0;
    rd_en = 1'b0;
    rd_addr = dec ? 4'd15 : 4'd0;
    case (state_r)
      ST_PRE_E: begin
        f_a = pre_sel_r ? k4_r : k3_r;
        f_b = pre_sel_r ? k3_r : k4_r;
      end
      ST_KS_E: begin
        f_a = add_r;
        f_b = k2_r;
      end
      ST_KS_F: mem_we = (ks_sub_r == 2'd2);
      ST_BK_RD: rd_en = 1'b1;
      ST_BK_F: begin
        rd_en = (rnd_r != 4'd15);
        rd_addr = dec ? ~rnd_inc : rnd_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) sk_mem[ks_row_r] <= {sb0_r, sb1_r, sk};
    if (rd_en) rdata_r <= sk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
      key_size_r <= KEY_256;
      mode_r <= MODE_ECB_ENC;
      iv_l_r <= '0;
      iv_rt_r <= '0;
      sched_rdy_r <= 1'b0;
      chain_l_r <= '0;
      chain_rt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && fin_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_acc) begin
        case (cfg_index)
          CFG_KEY_A: key_a_r <= cfg_data;
          CFG_KEY_B: key_b_r <= cfg_data;
          CFG_KEY_C: key_c_r <= cfg_data;
          CFG_KEY_D: key_d_r <= cfg_data;
          CFG_KEY_SIZE: key_size_r <= cfg_data[1:0];
          CFG_MODE: mode_r <= cfg_data[2:0];
          CFG_IV_LEFT: iv_l_r <= cfg_data;
          CFG_IV_RIGHT: iv_rt_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_KS_F && ks_last) sched_rdy_r <= 1'b1;
      else if (cfg_acc && (cfg_index inside {[CFG_KEY_A:CFG_KEY_SIZE]})) sched_rdy_r <= 1'b0;
      if (in_acc && in_restart) begin
        chain_l_r <= iv_l_r;
        chain_rt_r <= iv_rt_r;
      end
      if (state_r == ST_FIN && fin_go) begin
        case (mode_r)
          MODE_CBC_ENC: begin
            chain_l_r <= blk_rt_r;
            chain_rt_r <= blk_l_r;
          end
          MODE_CBC_DEC: begin
            chain_l_r <= src_l_r;
            chain_rt_r <= src_rt_r;
          end
          MODE_CFB_ENC, MODE_CFB_DEC: begin
            chain_l_r <= {chain_l_r[62:0], chain_rt_r[63]};
            chain_rt_r <= {chain_rt_r[62:0], fb};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          msg_r <= in_block_right[0];
          src_l_r <= in_block_left;
          src_rt_r <= in_block_right;
          k4_r <= key_a_r;
          k3_r <= key_b_r;
          k2_r <= key_c_r;
          k1_r <= key_d_r;
          delta_r <= DELTA_WORD;
          pre_sel_r <= (key_size_r == KEY_192);
          ks_sub_r <= 2'd0;
          ks_row_r <= 4'd0;
          case (mode_r)
            MODE_CBC_ENC: begin
              blk_l_r <= in_block_left ^ ch_l;
              blk_rt_r <= in_block_right ^ ch_rt;
            end
            MODE_CFB_ENC, MODE_CFB_DEC: begin
              blk_l_r <= ch_l;
              blk_rt_r <= ch_rt;
            end
            default: begin
              blk_l_r <= in_block_left;
              blk_rt_r <= in_block_right;
            end
          endcase
        end
      end
      ST_PRE_F: begin
        if (pre_sel_r) begin
          k1_r <= f_out;
        end else begin
          k2_r <= f_out;
          pre_sel_r <= 1'b1;
        end
      end
      ST_KS_ADD: add_r <= k1_r + k3_r + delta_r;
      ST_KS_F: begin
        k4_r <= k3_r;
        k3_r <= k2_r;
        k2_r <= k1_r;
        k1_r <= sk;
        delta_r <= delta_r + DELTA_WORD;
        if (ks_sub_r == 2'd0) sb0_r <= sk;
        if (ks_sub_r == 2'd1) sb1_r <= sk;
        if (ks_sub_r == 2'd2) begin
          ks_sub_r <= 2'd0;
          ks_row_r <= ks_row_r + 4'd1;
        end else begin
          ks_sub_r <= ks_sub_r + 2'd1;
        end
      end
      ST_BK_RD: rnd_r <= 4'd0;
      ST_BK_ADD: t_r <= dec ? blk_rt_r - e2 : blk_rt_r + e0;
      ST_BK_F: begin
        blk_l_r <= dec ? t_r - e0 : t_r + e2;
        blk_rt_r <= blk_l_r ^ f_out;
        rnd_r <= rnd_inc;
      end
      ST_FIN: begin
        if (fin_go) begin
          case (mode_r)
            MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC: begin
              out_l_r <= blk_rt_r;
              out_rt_r <= blk_l_r;
            end
            MODE_CBC_DEC: begin
              out_l_r <= blk_rt_r ^ chain_l_r;
              out_rt_r <= blk_l_r ^ chain_rt_r;
            end
            MODE_CFB_ENC, MODE_CFB_DEC: begin
              out_l_r <= '0;
              out_rt_r <= {63'b0, cbit};
            end
            default: begin
              out_l_r <= '0;
              out_rt_r <= '0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule
